@@ rtl/core/imaxpq_pkg.sv @@
package imaxpq_pkg;

   localparam int HEAP_SLOTS_DEF = 64;
   localparam int COST_BITS_DEF = 32;
   localparam int HANDLES = 64;
   localparam int HANDLE_BITS = 6;
   localparam int COST_FIELD_BITS = 32;
   localparam int COUNT_FIELD_BITS = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE_MAX = 2'd1,
      OP_DELETE = 2'd2,
      OP_UPDATE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_EMPTY = 3'd1,
      ST_FULL = 3'd2,
      ST_ABSENT = 3'd3,
      ST_DUPLICATE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE = 4'd0,
      CMD_LOOKUP = 4'd1,
      CMD_INSERT = 4'd2,
      CMD_TAKE = 4'd3,
      CMD_SET_COST = 4'd4,
      CMD_READ_NODE = 4'd5,
      CMD_READ_PARENT = 4'd6,
      CMD_READ_LEFT = 4'd7,
      CMD_READ_RIGHT = 4'd8,
      CMD_SWAP_UP = 4'd9,
      CMD_SWAP_DOWN = 4'd10,
      CMD_RESULT = 4'd11
   } cmd_type;

   typedef struct packed {
      logic present;
      logic is_empty;
      logic is_full;
      logic take_last;
      logic has_parent;
      logic up_wins;
      logic has_left;
      logic has_right;
      logic down_wins;
   } stat_type;

endpackage

@@ rtl/core/imaxpq_path.sv @@
module imaxpq_path #(
   parameter int HEAP_SLOTS = imaxpq_pkg::HEAP_SLOTS_DEF,
   parameter int COST_BITS = imaxpq_pkg::COST_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input imaxpq_pkg::cmd_type cmd,
   input logic load,
   input logic [1:0] in_opcode,
   input logic [imaxpq_pkg::HANDLE_BITS-1:0] in_handle,
   input logic [imaxpq_pkg::COST_FIELD_BITS-1:0] in_cost,
   output imaxpq_pkg::stat_type stat,
   output logic [1:0] op_code,
   output logic [2:0] res_status,
   output logic [imaxpq_pkg::HANDLE_BITS-1:0] res_handle,
   output logic [imaxpq_pkg::COST_FIELD_BITS-1:0] res_cost,
   output logic [imaxpq_pkg::COUNT_FIELD_BITS-1:0] res_count
);
   import imaxpq_pkg::*;

   localparam int CAP = (HEAP_SLOTS < HANDLES) ? HEAP_SLOTS : HANDLES;
   localparam int CB = (COST_BITS < 32) ? COST_BITS : 32;
   localparam int IB = (CAP > 2) ? $clog2(CAP) : 1;
   localparam int CNTB = $clog2(CAP + 1);

   logic [HANDLE_BITS-1:0] hmem [CAP];
   logic signed [CB-1:0] cmem [CAP];
   logic [IB-1:0] pos_ff [HANDLES];
   logic [HANDLES-1:0] pres_ff;
   logic [CNTB-1:0] count_ff;

   logic [1:0] op_ff;
   logic [HANDLE_BITS-1:0] h_ff;
   logic signed [CB-1:0] c_ff;
   logic [IB-1:0] i_ff;
   logic [HANDLE_BITS-1:0] nh_ff, rh_ff;
   logic signed [CB-1:0] nc_ff, lc_ff;
   logic [HANDLE_BITS-1:0] lh_ff;
   logic [2:0] st_ff;
   logic [CB-1:0] rcost_ff;

   logic [IB-1:0] rd_addr;
   logic [HANDLE_BITS-1:0] rd_h;
   logic signed [CB-1:0] rd_c;
   logic [IB:0] left_w, right_w;
   logic [IB:0] cnt_ext;

   assign cnt_ext = (IB + 1)'(count_ff);
   assign left_w = {i_ff, 1'b1};
   assign right_w = left_w + 1'b1;

   always_comb begin
      rd_addr = i_ff;
      case (cmd)
         CMD_READ_PARENT: rd_addr = IB'((i_ff - 1'b1) >> 1);
         CMD_READ_LEFT: rd_addr = left_w[IB-1:0];
         CMD_READ_RIGHT: rd_addr = right_w[IB-1:0];
         CMD_TAKE: rd_addr = IB'(count_ff - 1'b1);
         default: rd_addr = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_h <= hmem[rd_addr];
      rd_c <= cmem[rd_addr];
   end

   logic [1:0] rphase_ff;
   always_ff @(posedge clock) begin
      if (cmd == CMD_READ_NODE) rphase_ff <= 2'd0;
      else if (cmd == CMD_READ_PARENT) rphase_ff <= 2'd1;
      else if (cmd == CMD_READ_LEFT) rphase_ff <= 2'd2;
      else if (cmd == CMD_READ_RIGHT) rphase_ff <= 2'd3;
   end

   always_comb begin
      stat.present = pres_ff[h_ff];
      stat.is_empty = (count_ff == '0);
      stat.is_full = (count_ff >= CNTB'(CAP));
      stat.take_last = (IB'(count_ff - 1'b1) == i_ff);
      stat.has_parent = (i_ff != '0);
      stat.up_wins = rd_c < nc_ff;
      stat.has_left = left_w < cnt_ext;
      stat.has_right = right_w < cnt_ext;
      stat.down_wins = (rphase_ff == 2'd3) ?
         ((rd_c > lc_ff) ? (rd_c > nc_ff) : (lc_ff > nc_ff)) : (lc_ff > nc_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_READ_LEFT) begin
      end
      if (rphase_ff == 2'd2 && cmd != CMD_READ_LEFT) begin
         lh_ff <= rd_h;
         lc_ff <= rd_c;
      end
   end

   logic [IB-1:0] child_sel;
   logic [HANDLE_BITS-1:0] ch_h;
   logic signed [CB-1:0] ch_c;
   always_comb begin
      if (rphase_ff == 2'd3 && rd_c > lc_ff) begin
         child_sel = right_w[IB-1:0];
         ch_h = rd_h;
         ch_c = rd_c;
      end else begin
         child_sel = left_w[IB-1:0];
         ch_h = lh_ff;
         ch_c = lc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= in_opcode;
         h_ff <= in_handle;
         c_ff <= CB'(in_cost);
         st_ff <= ST_OK;
         rh_ff <= '0;
         rcost_ff <= '0;
      end
      if (reset) begin
         pres_ff <= '0;
         count_ff <= '0;
      end else begin
         case (cmd)
            CMD_LOOKUP: begin
               i_ff <= (op_ff == OP_REMOVE_MAX) ? '0 : pos_ff[h_ff];
               if (op_ff == OP_INSERT) begin
                  if (pres_ff[h_ff]) st_ff <= ST_DUPLICATE;
                  else if (count_ff >= CNTB'(CAP)) st_ff <= ST_FULL;
               end else if (op_ff == OP_REMOVE_MAX) begin
                  if (count_ff == '0) st_ff <= ST_EMPTY;
               end else if (!pres_ff[h_ff]) st_ff <= ST_ABSENT;
            end
            CMD_INSERT: begin
               i_ff <= IB'(count_ff);
               nh_ff <= h_ff;
               nc_ff <= c_ff;
               hmem[IB'(count_ff)] <= h_ff;
               cmem[IB'(count_ff)] <= c_ff;
               pos_ff[h_ff] <= IB'(count_ff);
               count_ff <= count_ff + 1'b1;
            end
            CMD_TAKE: begin
               if (op_ff == OP_REMOVE_MAX) begin
                  rh_ff <= rd_h;
                  rcost_ff <= rd_c;
                  pres_ff[rd_h] <= 1'b0;
               end else begin
                  pres_ff[h_ff] <= 1'b0;
               end
               count_ff <= count_ff - 1'b1;
            end
            CMD_SET_COST: begin
               if (op_ff == OP_UPDATE) begin
                  nh_ff <= h_ff;
                  nc_ff <= c_ff;
                  cmem[i_ff] <= c_ff;
               end else begin
                  nh_ff <= rd_h;
                  nc_ff <= rd_c;
                  hmem[i_ff] <= rd_h;
                  cmem[i_ff] <= rd_c;
                  pos_ff[rd_h] <= i_ff;
               end
            end
            CMD_SWAP_UP: begin
               hmem[i_ff] <= rd_h;
               cmem[i_ff] <= rd_c;
               pos_ff[rd_h] <= i_ff;
               hmem[IB'((i_ff - 1'b1) >> 1)] <= nh_ff;
               cmem[IB'((i_ff - 1'b1) >> 1)] <= nc_ff;
               pos_ff[nh_ff] <= IB'((i_ff - 1'b1) >> 1);
               i_ff <= IB'((i_ff - 1'b1) >> 1);
            end
            CMD_SWAP_DOWN: begin
               hmem[i_ff] <= ch_h;
               cmem[i_ff] <= ch_c;
               pos_ff[ch_h] <= i_ff;
               hmem[child_sel] <= nh_ff;
               cmem[child_sel] <= nc_ff;
               pos_ff[nh_ff] <= child_sel;
               i_ff <= child_sel;
            end
            default: begin
            end
         endcase
         if (cmd == CMD_INSERT) pres_ff[h_ff] <= 1'b1;
      end
   end

   assign op_code = op_ff;
   assign res_status = st_ff;
   assign res_handle = rh_ff;
   assign res_cost = COST_FIELD_BITS'(signed'(rcost_ff));
   assign res_count = COUNT_FIELD_BITS'(count_ff);

endmodule

@@ rtl/core/imaxpq_ctrl.sv @@
module imaxpq_ctrl (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input logic rsp_tready,
   input imaxpq_pkg::stat_type stat,
   input logic [1:0] op_code,
   input logic [2:0] res_status,
   output imaxpq_pkg::cmd_type cmd,
   output logic load,
   output logic capture
);
   import imaxpq_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_LOOK = 11'b00000000010,
      S_DISPATCH = 11'b00000000100,
      S_TAKE = 11'b00000001000,
      S_FILL = 11'b00000010000,
      S_RDNODE = 11'b00000100000,
      S_RDPAR = 11'b00001000000,
      S_UPCHK = 11'b00010000000,
      S_RDL = 11'b00100000000,
      S_RDR = 11'b01000000000,
      S_DNCHK = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic vld_ff, vld_in;

   assign req_tready = (state_ff == S_IDLE) && (!vld_ff || rsp_tready);
   assign load = req_tvalid && req_tready;
   assign rsp_tvalid = vld_ff;

   always_comb begin
      state_in = state_ff;
      cmd = CMD_NONE;
      capture = 1'b0;
      case (state_ff)
         S_IDLE: if (load) state_in = S_LOOK;
         S_LOOK: begin
            cmd = CMD_LOOKUP;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (res_status != ST_OK) begin
               capture = 1'b1;
               state_in = S_IDLE;
            end else if (op_code == OP_INSERT) begin
               cmd = CMD_INSERT;
               state_in = S_UPCHK;
            end else if (op_code == OP_UPDATE) begin
               cmd = CMD_SET_COST;
               state_in = S_UPCHK;
            end else begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            cmd = CMD_TAKE;
            if (stat.take_last) state_in = S_RDL;
            else state_in = S_FILL;
         end
         S_FILL: begin
            cmd = CMD_SET_COST;
            state_in = S_UPCHK;
         end
         S_UPCHK: begin
            if (stat.has_parent) begin
               cmd = CMD_READ_PARENT;
               state_in = S_RDPAR;
            end else state_in = S_RDL;
         end
         S_RDPAR: begin
            if (stat.up_wins) begin
               cmd = CMD_SWAP_UP;
               state_in = S_RDNODE;
            end else state_in = S_RDL;
         end
         S_RDNODE: begin
            cmd = CMD_READ_PARENT;
            state_in = stat.has_parent ? S_RDPAR : S_RDL;
            if (!stat.has_parent) begin
               capture = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RDL: begin
            if (stat.has_left) begin
               cmd = CMD_READ_LEFT;
               state_in = S_RDR;
            end else begin
               capture = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RDR: begin
            if (stat.has_right) cmd = CMD_READ_RIGHT;
            state_in = S_DNCHK;
         end
         S_DNCHK: begin
            if (stat.down_wins) begin
               cmd = CMD_SWAP_DOWN;
               state_in = S_RDL;
            end else begin
               capture = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (rsp_tready) vld_in = 1'b0;
      if (capture) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

endmodule

@@ rtl/core/indexed_max_priority_queue.sv @@
// Indexed max-heap of up to 64 handles with signed costs.
// req_ channel: one word per operation (insert, remove max, delete, update).
// rsp_ channel: exactly one word per request: status, removed entry, count.
// A refused operation gets its result word as soon as the lookup has set its
// status. Other operations insert, set the new cost, or take a slot and,
// unless it was the last, refill it from the last slot; then the entry moves
// up a level per parent read and swap, or down a level per read of both
// children and swap. The slot memory has a single read port, so each level
// reads the parent or both children before a swap.
// One operation is in flight at a time. The result sits in an output
// register; the next request is taken as soon as that register is free or
// is being emptied, so a stalled receiver only holds off new requests.
// Reset clears the count and all handle present bits at once; no sweep.
// Slot contents are undefined until written, and slot values above the
// count are never used.
module indexed_max_priority_queue #(
   parameter int HEAP_SLOTS = imaxpq_pkg::HEAP_SLOTS_DEF,
   parameter int COST_BITS = imaxpq_pkg::COST_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [39:0] req_tdata, // opcode[1:0], entry_handle[7:2], entry_cost[39:8]
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [47:0] rsp_tdata // status[2:0], removed_handle[8:3], removed_cost[40:9],
                                 // entry_count[47:41]
);
   import imaxpq_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic load, capture;
   logic [1:0] op_code;
   logic [2:0] res_status;
   logic [HANDLE_BITS-1:0] res_handle;
   logic [COST_FIELD_BITS-1:0] res_cost;
   logic [COUNT_FIELD_BITS-1:0] res_count;
   logic [47:0] out_ff;

   imaxpq_path #(.HEAP_SLOTS(HEAP_SLOTS), .COST_BITS(COST_BITS)) u_path (
      .clock(clock), .reset(reset), .cmd(cmd), .load(load),
      .in_opcode(req_tdata[1:0]), .in_handle(req_tdata[7:2]),
      .in_cost(req_tdata[39:8]), .stat(stat), .op_code(op_code),
      .res_status(res_status), .res_handle(res_handle), .res_cost(res_cost),
      .res_count(res_count)
   );

   imaxpq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .op_code(op_code), .res_status(res_status), .cmd(cmd),
      .load(load), .capture(capture)
   );

   always_ff @(posedge clock) begin
      if (capture) out_ff <= {res_count, res_cost, res_handle, res_status};
   end
   assign rsp_tdata = out_ff;

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      load |=> !req_tready) else $error("request taken while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:41] <= 7'd64) else $error("count out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      capture |-> !rsp_tvalid) else $error("overwrite");

endmodule

@@ tb/sv/indexed_max_priority_queue_test.sv @@
module indexed_max_priority_queue_test;
   import imaxpq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 2000;

   typedef struct packed {
      logic [31:0] cost;
      logic [5:0] handle;
      opcode_type op;
   } op_word_type;

   typedef struct packed {
      logic [6:0] count;
      logic [31:0] cost;
      logic [5:0] handle;
      status_type status;
   } result_word_type;

   typedef struct {
      op_word_type req;
      bit typed;
      result_word_type rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   indexed_max_priority_queue dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [5:0] heap_handle [64];
   logic signed [31:0] heap_cost [64];
   int slot_of [64];
   bit in_heap [64];
   int heap_size;

   result_word_type expected_results [$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 23;
   int recv_idle_pct = 55;
   int results_seen = 0;
   int status_seen [5];

   function automatic void swap_slots(int a, int b);
      logic [5:0] h;
      logic signed [31:0] c;
      h = heap_handle[a];
      c = heap_cost[a];
      heap_handle[a] = heap_handle[b];
      heap_cost[a] = heap_cost[b];
      heap_handle[b] = h;
      heap_cost[b] = c;
      slot_of[heap_handle[a]] = a;
      slot_of[heap_handle[b]] = b;
   endfunction

   function automatic void sift_up(int i);
      while (i > 0 && heap_cost[i] > heap_cost[(i - 1) / 2]) begin
         swap_slots(i, (i - 1) / 2);
         i = (i - 1) / 2;
      end
   endfunction

   function automatic void sift_down(int i);
      int c;
      forever begin
         c = 2 * i + 1;
         if (c >= heap_size) break;
         if (c + 1 < heap_size && heap_cost[c + 1] > heap_cost[c]) c++;
         if (!(heap_cost[c] > heap_cost[i])) break;
         swap_slots(i, c);
         i = c;
      end
   endfunction

   function automatic void resift(int i);
      if (i > 0 && heap_cost[i] > heap_cost[(i - 1) / 2]) sift_up(i);
      else sift_down(i);
   endfunction

   function automatic void take_slot(int i);
      int last;
      last = heap_size - 1;
      in_heap[heap_handle[i]] = 1'b0;
      heap_size = last;
      if (i != last) begin
         heap_handle[i] = heap_handle[last];
         heap_cost[i] = heap_cost[last];
         slot_of[heap_handle[i]] = i;
         resift(i);
      end
   endfunction

   function automatic result_word_type apply_op(op_word_type w);
      result_word_type r;
      r = '0;
      r.status = ST_OK;
      case (w.op)
         OP_INSERT: begin
            if (in_heap[w.handle]) r.status = ST_DUPLICATE;
            else if (heap_size >= 64) r.status = ST_FULL;
            else begin
               heap_handle[heap_size] = w.handle;
               heap_cost[heap_size] = w.cost;
               slot_of[w.handle] = heap_size;
               in_heap[w.handle] = 1'b1;
               heap_size++;
               sift_up(heap_size - 1);
            end
         end
         OP_REMOVE_MAX: begin
            if (heap_size == 0) r.status = ST_EMPTY;
            else begin
               r.handle = heap_handle[0];
               r.cost = heap_cost[0];
               take_slot(0);
            end
         end
         default: begin
            if (!in_heap[w.handle]) r.status = ST_ABSENT;
            else if (w.op == OP_DELETE) take_slot(slot_of[w.handle]);
            else begin
               heap_cost[slot_of[w.handle]] = w.cost;
               resift(slot_of[w.handle]);
            end
         end
      endcase
      r.count = 7'(heap_size);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      result_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (got.status <= ST_DUPLICATE) status_seen[got.status]++;
         if (expected_results.size() == 0) begin
            $display("%0t unexpected word %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
               $display("%0t status exp %0d got %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.handle !== want.handle) begin
               $display("%0t handle exp %0d got %0d", $time, want.handle, got.handle);
               errors++;
            end
            if (got.cost !== want.cost) begin
               $display("%0t cost exp %h got %h", $time, want.cost, got.cost);
               errors++;
            end
            if (got.count !== want.count) begin
               $display("%0t count exp %0d got %0d", $time, want.count, got.count);
               errors++;
            end
         end
      end
   end

   task automatic send_word(op_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.insert(expected_results.size(), apply_op(w));
   endtask

   function automatic op_word_type random_word();
      op_word_type w;
      int pick;
      w.handle = 6'($urandom_range(63));
      case ($urandom_range(5))
         0: w.cost = 32'h8000_0000;
         1: w.cost = 32'h7fff_ffff;
         2: w.cost = 32'($urandom_range(7));
         default: w.cost = $urandom;
      endcase
      pick = $urandom_range(99);
      if (heap_size < 20) w.op = (pick < 55) ? OP_INSERT : opcode_type'($urandom_range(3));
      else if (heap_size > 56) w.op = (pick < 25) ? OP_INSERT : opcode_type'($urandom_range(3));
      else w.op = opcode_type'($urandom_range(3));
      if (w.op != OP_INSERT && heap_size > 0 && pick % 4 != 0)
         w.handle = heap_handle[$urandom_range(heap_size - 1)];
      return w;
   endfunction

   directed_row_type directed [$];

   function automatic void add_row(opcode_type op, int h, logic [31:0] c, bit typed,
                                   status_type st, int rh, logic [31:0] rc, int n);
      directed_row_type d;
      d.req = '{cost: c, handle: 6'(h), op: op};
      d.typed = typed;
      d.rsp = '{count: 7'(n), cost: rc, handle: 6'(rh), status: st};
      directed.insert(directed.size(), d);
   endfunction

   initial begin
      result_word_type want;
      add_row(OP_REMOVE_MAX, 0, 0, 1, ST_EMPTY, 0, 0, 0);
      add_row(OP_DELETE, 5, 0, 1, ST_ABSENT, 0, 0, 0);
      add_row(OP_UPDATE, 63, 0, 1, ST_ABSENT, 0, 0, 0);
      add_row(OP_INSERT, 0, 32'h8000_0000, 1, ST_OK, 0, 0, 1);
      add_row(OP_INSERT, 0, 32'h0, 1, ST_DUPLICATE, 0, 0, 1);
      add_row(OP_INSERT, 63, 32'h7fff_ffff, 1, ST_OK, 0, 0, 2);
      add_row(OP_INSERT, 21, 32'h7fff_ffff, 1, ST_OK, 0, 0, 3);
      add_row(OP_INSERT, 42, 32'hffff_ffff, 1, ST_OK, 0, 0, 4);
      add_row(OP_REMOVE_MAX, 0, 0, 1, ST_OK, 63, 32'h7fff_ffff, 3);
      add_row(OP_UPDATE, 0, 32'h7fff_fffe, 0, ST_OK, 0, 0, 0);
      add_row(OP_UPDATE, 21, 32'h8000_0000, 0, ST_OK, 0, 0, 0);
      add_row(OP_DELETE, 42, 0, 0, ST_OK, 0, 0, 0);
      add_row(OP_DELETE, 21, 0, 0, ST_OK, 0, 0, 0);
      add_row(OP_REMOVE_MAX, 0, 0, 1, ST_OK, 0, 32'h7fff_fffe, 0);
      for (int i = 0; i < 64; i++) heap_size = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[k]) begin
         send_word(directed[k].req);
         if (directed[k].typed) begin
            want = expected_results[$];
            if (want !== directed[k].rsp) begin
               $display("%0t row %0d exp %h predictor %h", $time, k, directed[k].rsp, want);
               errors++;
            end
         end
      end
      // fill to capacity, then insert a handle that is already present
      for (int h = 0; h < 64; h++) send_word('{cost: $urandom, handle: 6'(h), op: OP_INSERT});
      send_word('{cost: 32'h1, handle: 6'd7, op: OP_INSERT});
      expected_results[$].status = expected_results[$].status;
      for (int h = 0; h < 64; h++)
         if (in_heap[h]) begin
            send_word('{cost: 32'h0, handle: 6'(h), op: OP_DELETE});
            break;
         end
      send_word('{cost: 32'h1, handle: 6'd0, op: OP_INSERT});
      send_word('{cost: 32'h1, handle: 6'd0, op: OP_INSERT});
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 23;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_word(random_word());
      end
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("covered %0d results: ok %0d empty %0d full %0d absent %0d duplicate %0d",
               results_seen, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3], status_seen[4]);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
